// ----- rtl/core/wsd_pkg.sv -----
package wsd_pkg;

	localparam int unsigned LENGTH_WIDTH_DEF = 64;

	localparam logic [7:0] CLOSE_KIND = 8'h88;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES = 3'd4;

	// One result request from the parser to the output stage.
	typedef struct packed {
		logic       empty_frame;
		logic       last_of_frame;
		logic [7:0] frame_kind;
		logic [7:0] data_byte;
	} res_t;

endpackage

// ----- rtl/core/websocket_frame_deframer.sv -----
// Channel  Dir  Group                      Contents
// s_       in   tvalid tready tdata[7:0]   rx_byte
// m_       out  tvalid tready tdata[7:0]   data_byte
//                tuser[8:0] tlast           frame_kind, empty_frame; last_of_frame
//
// One byte per cycle unless m_tready stalls: input register, one pass of parse logic, result register.
// A result is loaded from the input register into the result register once the output is free.
// Header bytes give no result; each payload byte or empty frame gives one.
// arst_n clears the parser to wait for a first header byte, and empties both registers.
// A stalled output holds its request; the input stalls only when both registers are full
// and m_tready is low.
module websocket_frame_deframer #(
	parameter int unsigned LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [8:0] m_tuser,   // [7:0] frame_kind, [8] empty_frame
	output logic       m_tlast    // last_of_frame
);
	import wsd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       free;
	logic       adv;
	logic       res_valid;
	res_t       res;

	assign adv = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	wsd_parser #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (adv),
		.rx_byte  (byte_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	wsd_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_valid),
		.res     (res),
		.free    (free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ----- rtl/core/wsd_parser.sv -----
module wsd_parser #(
	parameter int unsigned LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [7:0]    rx_byte,
	output logic          res_valid,
	output wsd_pkg::res_t res
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_KIND = 3'd0,
		PH_LEN  = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t                  phase_q, phase_n;
	logic [7:0]              kind_q, kind_n;
	logic [3:0]              ext_left_q, ext_left_n;
	logic [31:0]             key_q, key_n;
	logic [2:0]              key_left_q, key_left_n;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_n;
	logic [1:0]              kidx_q, kidx_n;
	logic                    closed_q, closed_n;
	logic                    hdr_done;
	logic [6:0]              len7;
	logic [7:0]              mask_byte;

	assign len7 = rx_byte[6:0];
	// key byte 0 sits in the top bits
	assign mask_byte = key_q[{~kidx_q, 3'b000} +: 8];

	always_comb begin
		phase_n = phase_q;
		kind_n = kind_q;
		ext_left_n = ext_left_q;
		key_n = key_q;
		key_left_n = key_left_q;
		rem_n = rem_q;
		kidx_n = kidx_q;
		closed_n = closed_q;
		hdr_done = 1'b0;
		res_valid = 1'b0;
		res = '{empty_frame: 1'b0, last_of_frame: 1'b0, frame_kind: kind_q,
			data_byte: 8'h00};
		if (go && !closed_q) begin
			unique case (phase_q)
				PH_LEN: begin
					key_left_n = rx_byte[7] ? KEY_BYTES : 3'd0;
					key_n = '0;
					kidx_n = '0;
					rem_n = '0;
					if (len7 == LEN_EXT16) begin
						ext_left_n = EXT16_BYTES;
					end else if (len7 == LEN_EXT64) begin
						ext_left_n = EXT64_BYTES;
					end else begin
						ext_left_n = '0;
						rem_n = LENGTH_WIDTH'(len7);
					end
					hdr_done = 1'b1;
				end
				PH_EXT: begin
					rem_n = {rem_q[LENGTH_WIDTH-9:0], rx_byte};
					ext_left_n = ext_left_q - 4'd1;
					hdr_done = 1'b1;
				end
				PH_KEY: begin
					key_n = {key_q[23:0], rx_byte};
					key_left_n = key_left_q - 3'd1;
					hdr_done = 1'b1;
				end
				PH_DATA: begin
					kidx_n = kidx_q + 2'd1;
					rem_n = rem_q - LENGTH_WIDTH'(1);
					res_valid = 1'b1;
					res.data_byte = rx_byte ^ mask_byte;
					res.last_of_frame = (rem_q == LENGTH_WIDTH'(1));
					if (rem_q == LENGTH_WIDTH'(1)) begin
						phase_n = PH_KIND;
						closed_n = (kind_q == CLOSE_KIND);
					end
				end
				default: begin
					// unused codes behave as the first header byte
					kind_n = rx_byte;
					phase_n = PH_LEN;
				end
			endcase
			if (hdr_done) begin
				priority if (ext_left_n != 4'd0) begin
					phase_n = PH_EXT;
				end else if (key_left_n != 3'd0) begin
					phase_n = PH_KEY;
				end else if (rem_n == '0) begin
					res_valid = 1'b1;
					res.last_of_frame = 1'b1;
					res.empty_frame = 1'b1;
					phase_n = PH_KIND;
					closed_n = (kind_q == CLOSE_KIND);
				end else begin
					phase_n = PH_DATA;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KIND;
			kind_q <= '0;
			ext_left_q <= '0;
			key_q <= '0;
			key_left_q <= '0;
			rem_q <= '0;
			kidx_q <= '0;
			closed_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			kind_q <= kind_n;
			ext_left_q <= ext_left_n;
			key_q <= key_n;
			key_left_q <= key_left_n;
			rem_q <= rem_n;
			kidx_q <= kidx_n;
			closed_q <= closed_n;
		end
	end

endmodule

// ----- rtl/core/wsd_out_stage.sv -----
module wsd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  wsd_pkg::res_t res,
	output logic          free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,  // [7:0] data_byte
	output logic [8:0]    m_tuser,  // [7:0] frame_kind, [8] empty_frame
	output logic          m_tlast   // last_of_frame
);
	import wsd_pkg::*;

	logic valid_q;
	res_t res_q;

	// slot can take a new result when empty or draining this cycle
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = res_q.data_byte;
	assign m_tuser = {res_q.empty_frame, res_q.frame_kind};
	assign m_tlast = res_q.last_of_frame;

endmodule

// ----- rtl/core/wsd_checker.sv -----
module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [8:0] m_tuser,
	input logic       m_tlast
);
	import wsd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output request changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[8] |-> m_tlast)
		else $error("empty frame result without last mark");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[8] |-> m_tdata == 8'h00)
		else $error("empty frame result carries data");

	a_close_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && m_tuser[7:0] == CLOSE_KIND |=> !m_tvalid)
		else $error("result after final close frame");

endmodule

bind websocket_frame_deframer wsd_checker u_chk (.*);

// ----- tb/sv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	localparam int STIM_BYTES     = 1100;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 300;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_WIDTH_DEF);

	typedef enum logic [2:0] {
		WAIT_KIND,
		WAIT_LEN,
		WAIT_EXT,
		WAIT_KEY,
		PAYLOAD
	} parse_step_t;

	typedef enum {
		FORM_SHORT,
		FORM_EXT16,
		FORM_EXT64
	} len_form_t;

	// Predicts deframer output and holds the results still owed by the block.
	class deframe_scoreboard;
		parse_step_t step;
		logic [7:0]  kind;
		logic [3:0]  ext_left;
		logic [31:0] key;
		logic [2:0]  key_left;
		logic [63:0] remaining;
		logic [1:0]  key_pos;
		bit          closed;
		res_t        pending_results[$];
		int          errors;
		int          results_seen;

		function new();
			step = WAIT_KIND;
			kind = '0;
			ext_left = '0;
			key = '0;
			key_left = '0;
			remaining = '0;
			key_pos = '0;
			closed = 1'b0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void push_result(logic [7:0] data, bit last, bit empty);
			res_t r;
			r.data_byte = data;
			r.frame_kind = kind;
			r.last_of_frame = last;
			r.empty_frame = empty;
			pending_results = {pending_results, r};
			if (last) begin
				if (kind == CLOSE_KIND)
					closed = 1'b1;
				step = WAIT_KIND;
			end
		endfunction

		// Extended length first, then mask key, then payload or the empty-frame result.
		function void header_part_done();
			if (ext_left != 0)
				step = WAIT_EXT;
			else if (key_left != 0)
				step = WAIT_KEY;
			else if (remaining == 0)
				push_result(8'h00, 1'b1, 1'b1);
			else
				step = PAYLOAD;
		endfunction

		function void take_rx_byte(logic [7:0] b);
			logic [7:0] key_byte;
			if (closed)
				return;
			case (step)
				WAIT_LEN: begin
					key_left = b[7] ? KEY_BYTES : 3'd0;
					key = '0;
					key_pos = '0;
					if (b[6:0] == LEN_EXT16) begin
						ext_left = EXT16_BYTES;
						remaining = '0;
					end else if (b[6:0] == LEN_EXT64) begin
						ext_left = EXT64_BYTES;
						remaining = '0;
					end else begin
						ext_left = '0;
						remaining = 64'(b[6:0]);
					end
					header_part_done();
				end
				WAIT_EXT: begin
					remaining = ((remaining << 8) | 64'(b)) & LEN_MASK;
					ext_left = ext_left - 4'd1;
					header_part_done();
				end
				WAIT_KEY: begin
					key = {key[23:0], b};
					key_left = key_left - 3'd1;
					header_part_done();
				end
				PAYLOAD: begin
					key_byte = 8'(key >> (24 - 8 * int'(key_pos)));
					key_pos = key_pos + 2'd1;
					remaining = (remaining - 64'd1) & LEN_MASK;
					push_result(b ^ key_byte, remaining == 0, 1'b0);
				end
				default: begin
					kind = b;
					step = WAIT_LEN;
				end
			endcase
		endfunction

		function void check_result(res_t got);
			res_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result: data=%h kind=%h last=%b empty=%b",
						got.data_byte, got.frame_kind, got.last_of_frame, got.empty_frame);
				return;
			end
			want = pending_results.pop_front();
			if (got.data_byte !== want.data_byte || got.frame_kind !== want.frame_kind ||
				got.last_of_frame !== want.last_of_frame ||
				got.empty_frame !== want.empty_frame) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display({"result %0d: expected data=%h kind=%h last=%b empty=%b,",
						" got data=%h kind=%h last=%b empty=%b"},
						results_seen, want.data_byte, want.frame_kind, want.last_of_frame,
						want.empty_frame, got.data_byte, got.frame_kind, got.last_of_frame,
						got.empty_frame);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [8:0] m_tuser;
	logic       m_tlast;

	deframe_scoreboard frame_checker = new();
	logic [7:0]        rx_stream[$];
	int                idle_cycles = 0;

	always #10 clk = ~clk;

	websocket_frame_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	function automatic void add_byte(logic [7:0] b);
		rx_stream = {rx_stream, b};
	endfunction

	task automatic add_header(logic [7:0] kind, len_form_t form, logic [63:0] len,
		bit masked, logic [31:0] key);
		add_byte(kind);
		case (form)
			FORM_SHORT: add_byte({masked, len[6:0]});
			FORM_EXT16: begin
				add_byte({masked, LEN_EXT16});
				add_byte(len[15:8]);
				add_byte(len[7:0]);
			end
			default: begin
				add_byte({masked, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					add_byte(8'(len >> (8 * i)));
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				add_byte(8'(key >> (8 * i)));
	endtask

	task automatic add_random_bytes(int count);
		for (int i = 0; i < count; i++)
			add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic build_stimulus();
		logic [7:0]  kind;
		logic [63:0] len;
		len_form_t   form;
		int          pick;

		// empty frames: short form, masked short form, non-minimal 16-bit zero
		add_header(8'h81, FORM_SHORT, 64'd0, 1'b0, 32'd0);
		add_header(8'h82, FORM_SHORT, 64'd0, 1'b1, 32'h12345678);
		add_header(8'h01, FORM_EXT16, 64'd0, 1'b0, 32'd0);
		// masked payload with extreme bytes
		add_header(8'hff, FORM_SHORT, 64'd2, 1'b1, 32'hff00aa55);
		add_byte(8'h00);
		add_byte(8'hff);
		// non-minimal 64-bit length; key must not carry over
		add_header(8'h00, FORM_EXT64, 64'd1, 1'b0, 32'd0);
		add_byte(8'ha5);

		while (rx_stream.size() < STIM_BYTES) begin
			do
				kind = 8'($urandom_range(0, 255));
			while (kind == CLOSE_KIND);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				form = FORM_SHORT;
				len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
					: 64'($urandom_range(0, 12));
			end else if (pick < 9) begin
				form = FORM_EXT16;
				len = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 300))
					: 64'($urandom_range(0, 40));
			end else begin
				form = FORM_EXT64;
				len = 64'($urandom_range(0, 40));
			end
			add_header(kind, form, len, 1'($urandom_range(0, 1)), $urandom());
			add_random_bytes(int'(len));
		end

		// closing frame with its two payload bytes, then bytes that must be ignored
		add_header(CLOSE_KIND, FORM_SHORT, 64'd2, 1'b1, $urandom());
		add_random_bytes(10);
	endtask

	task automatic send_stream();
		int gap;
		int count;
		bit burst;
		count = 0;
		burst = 1'b0;
		while (rx_stream.size() > 0) begin
			if (count % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			count++;
			gap = burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= rx_stream.pop_front();
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		s_tvalid <= 1'b0;
	endtask

	// Output side: random stalls, bursts of full rate, one long hold-off
	initial begin
		int gap;
		int count;
		bit burst;
		bit held;
		count = 0;
		burst = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && frame_checker.results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (count % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			count++;
			gap = burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				frame_checker.take_rx_byte(s_tdata);
			if (m_tvalid && m_tready)
				frame_checker.check_result({m_tuser[8], m_tlast, m_tuser[7:0], m_tdata});
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request accepted for %0d cycles", idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		build_stimulus();
		@(posedge clk);
		send_stream();
		while (frame_checker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (frame_checker.errors == 0 && frame_checker.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
